// ----- design/bib_pkg.sv -----
// Shared types, constants and helper functions for the ball integrate and bounce block.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package bib_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_GRAVITY_X   = 2'd0,
        CFG_GRAVITY_Y   = 2'd1,
        CFG_ARENA_W     = 2'd2,
        CFG_ARENA_H     = 2'd3
    } t_cfg_idx;

    // Unity in the Q1.16 damping format.
    localparam logic [16:0] Q_ONE = 17'h10000;

    localparam logic signed [31:0] INT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] INT_MIN = 32'sh80000000;

    // Pipeline depths.
    localparam int unsigned FRONT_STAGES = 3;
    localparam int unsigned SQRT_STAGES  = 17;
    localparam int unsigned DIV_STAGES   = 16;
    localparam int unsigned DAMP_STAGES  = DIV_STAGES + 5;
    localparam int unsigned LATENCY      = FRONT_STAGES + SQRT_STAGES + 4 * DAMP_STAGES;

    // Ball state carried alongside the arithmetic.
    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic [16:0]        s;
        logic               hs;
        logic               hf;
    } t_carry;

    // Saturate a 33-bit sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        begin
            if (v > 33'(INT_MAX)) begin
                r = INT_MAX;
            end else if (v < 33'(INT_MIN)) begin
                r = INT_MIN;
            end else begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

    // Negate, with the most negative value mapping to the largest positive one.
    function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
        logic signed [31:0] r;
        begin
            r = (v == INT_MIN) ? INT_MAX : -v;
            return r;
        end
    endfunction

    // Magnitude as an unsigned 32-bit value.
    function automatic logic [31:0] mag(input logic signed [31:0] v);
        logic [31:0] r;
        begin
            r = v[31] ? (~v[31:0] + 32'd1) : v[31:0];
            return r;
        end
    endfunction

endpackage

// ----- design/bib_sqrt.sv -----
// Pipelined integer square root, one result bit per stage, with a side payload.
// Depends on bib_pkg for the stage count.
`timescale 1ns / 1ps

module bib_sqrt #(
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [32:0]   i_n,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [16:0]   o_root,
    output logic [PW-1:0] o_pay
);

    localparam int NS = bib_pkg::SQRT_STAGES;

    logic [NS-1:0] r_valid;
    logic [33:0]   r_n    [NS];
    logic [33:0]   r_root [NS];
    logic [PW-1:0] r_pay  [NS];

    genvar j;
    generate
        for (j = 0; j < NS; j++) begin : g_stage
            localparam logic [33:0] BIT = 34'd1 << (2 * (NS - 1 - j));
            logic          valid_in;
            logic [PW-1:0] pay_in;
            logic [33:0]   n_in;
            logic [33:0]   root_in;
            logic [33:0]   trial;
            logic [33:0]   n_n;
            logic [33:0]   n_root;

            // Take the previous stage, or the input for the first one.
            if (j == 0) begin : g_first
                assign valid_in = i_valid;
                assign pay_in   = i_pay;
                assign n_in     = {1'b0, i_n};
                assign root_in  = '0;
            end else begin : g_rest
                assign valid_in = r_valid[j-1];
                assign pay_in   = r_pay[j-1];
                assign n_in     = r_n[j-1];
                assign root_in  = r_root[j-1];
            end

            // One restoring step of the digit-by-digit root.
            always_comb begin
                trial = root_in + BIT;
                if (n_in >= trial) begin
                    n_n    = n_in - trial;
                    n_root = (root_in >> 1) + BIT;
                end else begin
                    n_n    = n_in;
                    n_root = root_in >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[j] <= 1'b0;
                end else begin
                    r_valid[j] <= valid_in;
                end
            end

            always_ff @(posedge i_clk) begin
                r_n[j]    <= n_n;
                r_root[j] <= n_root;
                r_pay[j]  <= pay_in;
            end
        end
    endgenerate

    assign o_valid = r_valid[NS-1];
    assign o_root  = r_root[NS-1][16:0];
    assign o_pay   = r_pay[NS-1];

endmodule

// ----- design/bib_div.sv -----
// Pipelined fractional divider giving floor(n * 65536 / d) for n < d, one bit per stage.
// Depends on bib_pkg for the stage count.
`timescale 1ns / 1ps

module bib_div #(
    parameter int PW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [31:0]   i_n,
    input  logic [31:0]   i_d,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [15:0]   o_q,
    output logic [PW-1:0] o_pay
);

    localparam int NS = bib_pkg::DIV_STAGES;

    logic [NS-1:0] r_valid;
    logic [31:0]   r_rem [NS];
    logic [31:0]   r_d   [NS];
    logic [15:0]   r_q   [NS];
    logic [PW-1:0] r_pay [NS];

    genvar j;
    generate
        for (j = 0; j < NS; j++) begin : g_stage
            logic          valid_in;
            logic [PW-1:0] pay_in;
            logic [31:0]   rem_in;
            logic [31:0]   d_in;
            logic [15:0]   q_in;
            logic [32:0]   rem2;
            logic          ge;
            logic [32:0]   diff;

            if (j == 0) begin : g_first
                assign valid_in = i_valid;
                assign pay_in   = i_pay;
                assign rem_in   = i_n;
                assign d_in     = i_d;
                assign q_in     = '0;
            end else begin : g_rest
                assign valid_in = r_valid[j-1];
                assign pay_in   = r_pay[j-1];
                assign rem_in   = r_rem[j-1];
                assign d_in     = r_d[j-1];
                assign q_in     = r_q[j-1];
            end

            // Shift in a zero and subtract where the divisor fits.
            always_comb begin
                rem2 = {rem_in, 1'b0};
                ge   = (rem2 >= {1'b0, d_in});
                diff = rem2 - {1'b0, d_in};
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[j] <= 1'b0;
                end else begin
                    r_valid[j] <= valid_in;
                end
            end

            always_ff @(posedge i_clk) begin
                r_rem[j] <= ge ? diff[31:0] : rem2[31:0];
                r_d[j]   <= d_in;
                r_q[j]   <= {q_in[14:0], ge};
                r_pay[j] <= pay_in;
            end
        end
    endgenerate

    assign o_valid = r_valid[NS-1];
    assign o_q     = r_q[NS-1];
    assign o_pay   = r_pay[NS-1];

endmodule

// ----- design/bib_damp.sv -----
// One damping step of a bounce: factor from the ratio |rn|/|rd|, then scaling of a value.
// Depends on bib_pkg and bib_div.
`timescale 1ns / 1ps

module bib_damp #(
    parameter int PW = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_en,
    input  logic signed [31:0] i_rn,
    input  logic signed [31:0] i_rd,
    input  logic signed [31:0] i_val,
    input  logic [16:0]        i_s,
    input  logic [PW-1:0]      i_pay,
    output logic               o_valid,
    output logic signed [31:0] o_res,
    output logic [PW-1:0]      o_pay
);

    localparam int DW = PW + 32 + 17 + 2;

    // Operand stage: magnitudes and the case where the factor is just s.
    logic               r0_valid;
    logic [31:0]        r0_n;
    logic [31:0]        r0_d;
    logic               r0_special;
    logic signed [31:0] r0_val;
    logic [16:0]        r0_s;
    logic               r0_en;
    logic [PW-1:0]      r0_pay;

    logic [31:0] n_n;
    logic [31:0] n_d;

    always_comb begin
        n_n = bib_pkg::mag(i_rn);
        n_d = bib_pkg::mag(i_rd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_valid <= 1'b0;
        end else begin
            r0_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_n       <= n_n;
        r0_d       <= n_d;
        r0_special <= (n_d == 32'd0) || (n_n >= n_d);
        r0_val     <= i_val;
        r0_s       <= i_s;
        r0_en      <= i_en;
        r0_pay     <= i_pay;
    end

    // Ratio in Q0.16.
    logic          dv_valid;
    logic [15:0]   dv_q;
    logic [DW-1:0] dv_pay;

    bib_div #(.PW(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r0_valid),
        .i_n     (r0_n),
        .i_d     (r0_d),
        .i_pay   ({r0_pay, r0_val, r0_s, r0_en, r0_special}),
        .o_valid (dv_valid),
        .o_q     (dv_q),
        .o_pay   (dv_pay)
    );

    logic [PW-1:0]      dv_top;
    logic signed [31:0] dv_val;
    logic [16:0]        dv_s;
    logic               dv_en;
    logic               dv_special;

    assign {dv_top, dv_val, dv_s, dv_en, dv_special} = dv_pay;

    // Stage one: (1 - s)(1 - q).
    logic               r1_valid;
    logic [33:0]        r1_prod;
    logic signed [31:0] r1_val;
    logic [16:0]        r1_s;
    logic               r1_en;
    logic               r1_special;
    logic [PW-1:0]      r1_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_prod    <= (bib_pkg::Q_ONE - dv_s) * (bib_pkg::Q_ONE - {1'b0, dv_q});
        r1_val     <= dv_val;
        r1_s       <= dv_s;
        r1_en      <= dv_en;
        r1_special <= dv_special;
        r1_pay     <= dv_top;
    end

    // Stage two: the damping factor.
    logic               r2_valid;
    logic [16:0]        r2_f;
    logic signed [31:0] r2_val;
    logic               r2_en;
    logic [PW-1:0]      r2_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_f   <= r1_special ? r1_s : (r1_s + r1_prod[32:16]);
        r2_val <= r1_val;
        r2_en  <= r1_en;
        r2_pay <= r1_pay;
    end

    // Stage three: magnitude times factor.
    logic               r3_valid;
    logic [48:0]        r3_p;
    logic signed [31:0] r3_val;
    logic               r3_en;
    logic [PW-1:0]      r3_pay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_p   <= bib_pkg::mag(r2_val) * r2_f;
        r3_val <= r2_val;
        r3_en  <= r2_en;
        r3_pay <= r2_pay;
    end

    // Stage four: truncate toward zero and restore the sign, or pass the value through when not enabled.
    logic               r4_valid;
    logic signed [31:0] r4_res;
    logic [PW-1:0]      r4_pay;
    logic [31:0]        n_pr;

    assign n_pr = r3_p[47:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r3_en) begin
            r4_res <= r3_val;
        end else if (r3_val[31]) begin
            r4_res <= -n_pr;
        end else begin
            r4_res <= n_pr;
        end
        r4_pay <= r3_pay;
    end

    assign o_valid = r4_valid;
    assign o_res   = r4_res;
    assign o_pay   = r4_pay;

endmodule

// ----- design/ball_integrate_and_wall_bounce.sv -----
// Top level of the ball integrate and wall bounce block.
// Depends on bib_pkg, bib_sqrt and bib_damp.
`timescale 1ns / 1ps

// Usage
// An item is one ball: position, velocity, radius and elasticity. It is taken
// at a rising edge with start high and busy low. busy is never raised, so a
// ball can be issued in every cycle.
// A result follows each transfer: o_valid is high for one
// cycle with the new position, velocity and the two wall hit flags. One result
// per ball, in order, one per cycle at full rate.
// The pipeline holds gravity, integration and wall tests, the elasticity square
// root (one bit a stage) and four damping steps, each led by a 16-stage
// one-bit-a-stage divider.
// The configuration channel (gravity and arena size) is always ready; write it
// only while no ball is in flight.
// A synchronous reset empties the pipeline and returns the registers to gravity
// (0, 1.0) and an 800 by 600 arena. The receiver cannot stall the block: results
// are shown for one cycle only and must be taken then.

module ball_integrate_and_wall_bounce #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic [10:0]        i_ball_radius,
    input  logic [16:0]        i_elasticity,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    output logic               o_valid,
    output logic signed [31:0] o_new_pos_x,
    output logic signed [31:0] o_new_pos_y,
    output logic signed [31:0] o_new_vel_x,
    output logic signed [31:0] o_new_vel_y,
    output logic               o_hit_side,
    output logic               o_hit_floor_ceiling
);

    localparam int WW = 14 + FRAC_BITS + 2;
    localparam logic signed [WW-1:0] SAT_HI = WW'(bib_pkg::INT_MAX);
    localparam logic signed [WW-1:0] SAT_LO = WW'(bib_pkg::INT_MIN);
    localparam int CW = $bits(bib_pkg::t_carry);

    function automatic logic signed [31:0] sat_w(input logic signed [WW-1:0] v);
        logic signed [31:0] r;
        begin
            if (v > SAT_HI) begin
                r = bib_pkg::INT_MAX;
            end else if (v < SAT_LO) begin
                r = bib_pkg::INT_MIN;
            end else begin
                r = v[31:0];
            end
            return r;
        end
    endfunction

    // Configuration registers.
    logic signed [31:0] r_grav_x;
    logic signed [31:0] r_grav_y;
    logic [13:0]        r_arena_w;
    logic [13:0]        r_arena_h;

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav_x  <= '0;
            r_grav_y  <= 32'sd65536;
            r_arena_w <= 14'd800;
            r_arena_h <= 14'd600;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (bib_pkg::t_cfg_idx'(i_cfg_index))
                bib_pkg::CFG_GRAVITY_X: r_grav_x  <= i_cfg_data;
                bib_pkg::CFG_GRAVITY_Y: r_grav_y  <= i_cfg_data;
                bib_pkg::CFG_ARENA_W:   r_arena_w <= i_cfg_data[13:0];
                bib_pkg::CFG_ARENA_H:   r_arena_h <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // Stage one: gravity into velocity, elasticity clamped to 1.0.
    logic               r1_valid;
    logic signed [31:0] r1_px, r1_py, r1_vx, r1_vy;
    logic [10:0]        r1_r;
    logic [16:0]        r1_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_px <= i_pos_x;
        r1_py <= i_pos_y;
        r1_vx <= bib_pkg::sat33(33'(i_vel_x) + 33'(r_grav_x));
        r1_vy <= bib_pkg::sat33(33'(i_vel_y) + 33'(r_grav_y));
        r1_r  <= i_ball_radius;
        r1_e  <= (i_elasticity > bib_pkg::Q_ONE) ? bib_pkg::Q_ONE : i_elasticity;
    end

    // Stage two: velocity into position.
    logic               r2_valid;
    logic signed [31:0] r2_px, r2_py, r2_vx, r2_vy;
    logic [10:0]        r2_r;
    logic [16:0]        r2_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_px <= bib_pkg::sat33(33'(r1_px) + 33'(r1_vx));
        r2_py <= bib_pkg::sat33(33'(r1_py) + 33'(r1_vy));
        r2_vx <= r1_vx;
        r2_vy <= r1_vy;
        r2_r  <= r1_r;
        r2_e  <= r1_e;
    end

    // Stage three: wall tests, clamps and the side-wall reversal of vx.
    logic signed [WW-1:0] n_r, n_w, n_h, n_px, n_py;
    logic                 n_left, n_right, n_top, n_bottom;
    bib_pkg::t_carry      n_c3;

    always_comb begin
        n_r      = WW'(signed'({1'b0, r2_r})) <<< FRAC_BITS;
        n_w      = WW'(signed'({1'b0, r_arena_w})) <<< FRAC_BITS;
        n_h      = WW'(signed'({1'b0, r_arena_h})) <<< FRAC_BITS;
        n_px     = WW'(r2_px);
        n_py     = WW'(r2_py);
        n_left   = n_px < n_r;
        n_right  = n_px > (n_w - n_r);
        n_top    = n_py < n_r;
        n_bottom = n_py > (n_h - n_r);
        n_c3.hs  = n_left || n_right;
        n_c3.hf  = n_top || n_bottom;
        n_c3.px  = n_left ? sat_w(n_r) : (n_right ? sat_w(n_w - n_r) : r2_px);
        n_c3.py  = n_top ? sat_w(n_r) : (n_bottom ? sat_w(n_h - n_r) : r2_py);
        n_c3.vx  = n_c3.hs ? bib_pkg::neg_sat(r2_vx) : r2_vx;
        n_c3.vy  = r2_vy;
        n_c3.s   = '0;
    end

    logic            r3_valid;
    bib_pkg::t_carry r3_c;
    logic [16:0]     r3_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_c <= n_c3;
        r3_e <= r2_e;
    end

    // Square root of the elasticity gives the base damping factor.
    logic            sq_valid;
    logic [16:0]     sq_root;
    logic [CW-1:0]   sq_pay;
    bib_pkg::t_carry c0;

    bib_sqrt #(.PW(CW)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_valid),
        .i_n     ({r3_e, 16'd0}),
        .i_pay   (r3_c),
        .o_valid (sq_valid),
        .o_root  (sq_root),
        .o_pay   (sq_pay)
    );

    always_comb begin
        c0   = bib_pkg::t_carry'(sq_pay);
        c0.s = sq_root;
    end

    // Side wall, first vx then vy with the new vx.
    logic               d1_valid, d2_valid, d3_valid, d4_valid;
    logic signed [31:0] d1_res, d2_res, d3_res, d4_res;
    logic [CW-1:0]      d1_pay, d2_pay, d3_pay, d4_pay;
    bib_pkg::t_carry    c1, c2, c3, c4;
    logic signed [31:0] n_vy_neg;

    bib_damp #(.PW(CW)) u_damp_sx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_valid),
        .i_en    (c0.hs),
        .i_rn    (c0.vx),
        .i_rd    (c0.vy),
        .i_val   (c0.vx),
        .i_s     (c0.s),
        .i_pay   (c0),
        .o_valid (d1_valid),
        .o_res   (d1_res),
        .o_pay   (d1_pay)
    );

    always_comb begin
        c1    = bib_pkg::t_carry'(d1_pay);
        c1.vx = d1_res;
    end

    bib_damp #(.PW(CW)) u_damp_sy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d1_valid),
        .i_en    (c1.hs),
        .i_rn    (c1.vx),
        .i_rd    (c1.vy),
        .i_val   (c1.vy),
        .i_s     (c1.s),
        .i_pay   (c1),
        .o_valid (d2_valid),
        .o_res   (d2_res),
        .o_pay   (d2_pay)
    );

    // Floor and ceiling: reverse vy, scale it, then vx with the new vy.
    always_comb begin
        c2       = bib_pkg::t_carry'(d2_pay);
        c2.vy    = d2_res;
        n_vy_neg = c2.hf ? bib_pkg::neg_sat(d2_res) : d2_res;
    end

    bib_damp #(.PW(CW)) u_damp_fy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d2_valid),
        .i_en    (c2.hf),
        .i_rn    (n_vy_neg),
        .i_rd    (c2.vx),
        .i_val   (n_vy_neg),
        .i_s     (c2.s),
        .i_pay   (c2),
        .o_valid (d3_valid),
        .o_res   (d3_res),
        .o_pay   (d3_pay)
    );

    always_comb begin
        c3    = bib_pkg::t_carry'(d3_pay);
        c3.vy = d3_res;
    end

    bib_damp #(.PW(CW)) u_damp_fx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (d3_valid),
        .i_en    (c3.hf),
        .i_rn    (c3.vy),
        .i_rd    (c3.vx),
        .i_val   (c3.vx),
        .i_s     (c3.s),
        .i_pay   (c3),
        .o_valid (d4_valid),
        .o_res   (d4_res),
        .o_pay   (d4_pay)
    );

    always_comb begin
        c4    = bib_pkg::t_carry'(d4_pay);
        c4.vx = d4_res;
    end

    // Results come straight from the last damping register.
    assign o_valid             = d4_valid;
    assign o_new_pos_x         = c4.px;
    assign o_new_pos_y         = c4.py;
    assign o_new_vel_x         = c4.vx;
    assign o_new_vel_y         = c4.vy;
    assign o_hit_side          = c4.hs;
    assign o_hit_floor_ceiling = c4.hf;

endmodule

// ----- design/bib_checker.sv -----
// Port-level checker for the ball integrate and bounce block, bound to the top level.
// Depends on bib_pkg for the pipeline latency.
`timescale 1ns / 1ps

module bib_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_valid,
    input logic o_hit_side,
    input logic o_hit_floor_ceiling
);

    localparam int LAT = bib_pkg::LATENCY;

    // The block never holds off a ball.
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    // Reset empties the pipeline.
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe after reset");

    // Every result stems from a transfer exactly one latency earlier.
    a_result_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, LAT))
        else $error("result without a matching transfer");

    // Hit flags only mean something with the strobe; they must not be unknown then.
    a_flags_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !$isunknown({o_hit_side, o_hit_floor_ceiling}))
        else $error("unknown hit flags on a result");

endmodule

bind ball_integrate_and_wall_bounce bib_checker u_bib_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .start               (start),
    .busy                (busy),
    .o_valid             (o_valid),
    .o_hit_side          (o_hit_side),
    .o_hit_floor_ceiling (o_hit_floor_ceiling)
);

// ----- verif/ball_bounce_checker.sv -----
// Checker for the ball integrate and wall bounce block: watches the ball, result
// and configuration channels, predicts each frame and compares it field by field.
// Depends on bib_pkg for the register indexes.
`timescale 1ns / 1ps

module ball_bounce_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic               i_busy,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic [10:0]        i_ball_radius,
    input  logic [16:0]        i_elasticity,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic signed [31:0] i_new_pos_x,
    input  logic signed [31:0] i_new_pos_y,
    input  logic signed [31:0] i_new_vel_x,
    input  logic signed [31:0] i_new_vel_y,
    input  logic               i_hit_side,
    input  logic               i_hit_floor_ceiling,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic               hs;
        logic               hf;
    } t_frame;

    // Local copy of the configuration registers.
    logic signed [31:0] grav_x;
    logic signed [31:0] grav_y;
    logic [13:0]        arena_w;
    logic [13:0]        arena_h;

    t_frame frames_due[$];

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic longint unsigned abs64(input logic signed [31:0] v);
        longint sv;
        sv = v;
        return (sv < 0) ? longint'(-sv) : longint'(sv);
    endfunction

    // Integer square root, one result bit per pass.
    function automatic longint unsigned root_of(input longint unsigned n);
        longint unsigned root;
        longint unsigned b;
        root = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n = n - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // Damping factor: the plain root, raised towards one for shallow ratios.
    function automatic longint unsigned damping(input longint unsigned s,
                                                input logic signed [31:0] num,
                                                input logic signed [31:0] den);
        longint unsigned n;
        longint unsigned d;
        longint unsigned q;
        n = abs64(num);
        d = abs64(den);
        if (d == 0 || n >= d) return s;
        q = (n << 16) / d;
        return s + (((65536 - s) * (65536 - q)) >> 16);
    endfunction

    // Scale the magnitude and restore the sign, truncating towards zero.
    function automatic logic signed [31:0] damp_vel(input logic signed [31:0] v,
                                                    input longint unsigned f);
        longint p;
        p = longint'((abs64(v) * f) >> 16);
        return (v < 0) ? clip32(-p) : clip32(p);
    endfunction

    function automatic t_frame next_frame(input logic signed [31:0] px0,
                                          input logic signed [31:0] py0,
                                          input logic signed [31:0] vx0,
                                          input logic signed [31:0] vy0,
                                          input logic [10:0] rad,
                                          input logic [16:0] el);
        t_frame f;
        longint r;
        longint w;
        longint h;
        longint unsigned e;
        longint unsigned s;
        longint t;
        r = longint'(rad) << 16;
        w = longint'(arena_w) << 16;
        h = longint'(arena_h) << 16;
        e = (el > 17'd65536) ? 65536 : el;
        s = root_of(e << 16);
        f.hs = 1'b0;
        f.hf = 1'b0;
        f.vx = clip32(longint'(vx0) + longint'(grav_x));
        f.vy = clip32(longint'(vy0) + longint'(grav_y));
        f.px = clip32(longint'(px0) + longint'(f.vx));
        f.py = clip32(longint'(py0) + longint'(f.vy));
        // Side walls: x is damped first, then y against the new x.
        t = f.px;
        if (t < r || t > w - r) begin
            f.hs = 1'b1;
            f.vx = clip32(-longint'(f.vx));
            f.vx = damp_vel(f.vx, damping(s, f.vx, f.vy));
            f.vy = damp_vel(f.vy, damping(s, f.vx, f.vy));
            f.px = (t < r) ? clip32(r) : clip32(w - r);
        end
        // Floor and ceiling, with the roles of the components swapped.
        t = f.py;
        if (t < r || t > h - r) begin
            f.hf = 1'b1;
            f.vy = clip32(-longint'(f.vy));
            f.vy = damp_vel(f.vy, damping(s, f.vy, f.vx));
            f.vx = damp_vel(f.vx, damping(s, f.vy, f.vx));
            f.py = (t < r) ? clip32(r) : clip32(h - r);
        end
        return f;
    endfunction

    always @(posedge i_clk) begin
        t_frame want;
        if (!i_rst_n) begin
            grav_x  <= 32'sd0;
            grav_y  <= 32'sd65536;
            arena_w <= 14'd800;
            arena_h <= 14'd600;
            frames_due.delete();
            o_errors = 0;
        end else begin
            // Configuration transfers.
            if (i_cfg_valid && i_cfg_ready) begin
                case (bib_pkg::t_cfg_idx'(i_cfg_index))
                    bib_pkg::CFG_GRAVITY_X: grav_x <= i_cfg_data;
                    bib_pkg::CFG_GRAVITY_Y: grav_y <= i_cfg_data;
                    bib_pkg::CFG_ARENA_W:   arena_w <= i_cfg_data[13:0];
                    bib_pkg::CFG_ARENA_H:   arena_h <= i_cfg_data[13:0];
                    default: ;
                endcase
            end
            // Ball transfers.
            if (i_start && !i_busy) begin
                frames_due = {frames_due, next_frame(i_pos_x, i_pos_y, i_vel_x, i_vel_y,
                                                     i_ball_radius, i_elasticity)};
            end
            // Result transfers.
            if (i_valid) begin
                if (frames_due.size() == 0) begin
                    o_errors = o_errors + 1;
                    if (o_errors <= 10) $display("Unexpected result at %0t", $realtime);
                end else begin
                    want = frames_due.pop_front();
                    if (want.px !== i_new_pos_x || want.py !== i_new_pos_y ||
                        want.vx !== i_new_vel_x || want.vy !== i_new_vel_y ||
                        want.hs !== i_hit_side || want.hf !== i_hit_floor_ceiling) begin
                        o_errors = o_errors + 1;
                        if (o_errors <= 10) begin
                            $display("Mismatch at %0t: expected p(%0d,%0d) v(%0d,%0d) hit %b%b",
                                     $realtime, want.px, want.py, want.vx, want.vy,
                                     want.hs, want.hf);
                            $display("  got p(%0d,%0d) v(%0d,%0d) hit %b%b",
                                     i_new_pos_x, i_new_pos_y, i_new_vel_x, i_new_vel_y,
                                     i_hit_side, i_hit_floor_ceiling);
                        end
                    end
                end
            end
        end
        o_pending = frames_due.size();
    end

    // Expectations left over show in o_pending; the top waits for it to reach zero before its verdict.
endmodule

// ----- verif/tb_ball_integrate_and_wall_bounce.sv -----
// Testbench top for the ball integrate and wall bounce block: drives balls and
// configuration in bursts, and gives the verdict from the checker's error count.
// Depends on bib_pkg, ball_bounce_checker and the block itself.
`timescale 1ns / 1ps

module tb_ball_integrate_and_wall_bounce;

    localparam int WATCHDOG_LIMIT = 4000;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
    logic [10:0]        radius;
    logic [16:0]        elast;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [31:0]        cfg_data;
    logic               res_valid;
    logic signed [31:0] res_px, res_py, res_vx, res_vy;
    logic               res_hs, res_hf;
    int                 errors;
    int                 pending;
    int                 idle_cycles;
    int                 arena_w, arena_h;

    ball_integrate_and_wall_bounce dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_vel_x(vel_x), .i_vel_y(vel_y),
        .i_ball_radius(radius), .i_elasticity(elast),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_valid(res_valid), .o_new_pos_x(res_px), .o_new_pos_y(res_py),
        .o_new_vel_x(res_vx), .o_new_vel_y(res_vy),
        .o_hit_side(res_hs), .o_hit_floor_ceiling(res_hf)
    );

    ball_bounce_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_busy(busy),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_vel_x(vel_x), .i_vel_y(vel_y),
        .i_ball_radius(radius), .i_elasticity(elast),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .i_valid(res_valid), .i_new_pos_x(res_px), .i_new_pos_y(res_py),
        .i_new_vel_x(res_vx), .i_new_vel_y(res_vy),
        .i_hit_side(res_hs), .i_hit_floor_ceiling(res_hf),
        .o_errors(errors), .o_pending(pending)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Watchdog: ends the run when nothing has been transferred for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || res_valid || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // One configuration transfer; called at a falling edge.
    task automatic write_reg(input bib_pkg::t_cfg_idx idx, input logic [31:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge i_clk); while (!cfg_ready);
        @(negedge i_clk);
        cfg_valid = 1'b0;
        if (idx == bib_pkg::CFG_ARENA_W) arena_w = value[13:0];
        if (idx == bib_pkg::CFG_ARENA_H) arena_h = value[13:0];
    endtask

    // Wait for the pipeline to drain before touching the registers.
    task automatic drain;
        while (pending != 0) @(negedge i_clk);
        repeat (bib_pkg::LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic setup_arena(input logic [31:0] gx, input logic [31:0] gy,
                               input logic [31:0] aw, input logic [31:0] ah);
        drain();
        write_reg(bib_pkg::CFG_GRAVITY_X, gx);
        write_reg(bib_pkg::CFG_GRAVITY_Y, gy);
        write_reg(bib_pkg::CFG_ARENA_W, aw);
        write_reg(bib_pkg::CFG_ARENA_H, ah);
    endtask

    // One ball transfer; called at a falling edge, returns at a falling edge.
    task automatic send_ball(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] vx, input logic [31:0] vy,
                             input logic [10:0] r, input logic [16:0] e);
        start  = 1'b1;
        pos_x  = px;
        pos_y  = py;
        vel_x  = vx;
        vel_y  = vy;
        radius = r;
        elast  = e;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic pause(input int n);
        start = 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    // A coordinate across an axis with a 48-unit margin beyond each wall, or anywhere in 32 bits now and then.
    function automatic logic [31:0] coord(input int span);
        if ($urandom_range(0, 9) == 0) return $urandom;
        return ((int'($urandom_range(0, span + 96)) - 48) <<< 16) + $urandom_range(0, 65535);
    endfunction

    function automatic logic [31:0] speed();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'(int'($urandom_range(0, 255)) - 128);
            default: return 32'(int'($urandom_range(0, 32'h00400000)) - 32'sh00200000);
        endcase
    endfunction

    task automatic random_balls(input int count);
        int left;
        int burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 40);
            for (int k = 0; k < burst && left > 0; k++) begin
                send_ball(coord(arena_w), coord(arena_h), speed(), speed(),
                          ($urandom_range(0, 7) == 0) ? 11'($urandom) :
                              11'($urandom_range(0, 40)),
                          ($urandom_range(0, 5) == 0) ? 17'($urandom) :
                              17'($urandom_range(0, 65536)));
                left--;
            end
            if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 20));
        end
        pause(1);
    endtask

    initial begin
        start = 1'b0; pos_x = '0; pos_y = '0; vel_x = '0; vel_y = '0;
        radius = '0; elast = '0;
        cfg_valid = 1'b0; cfg_index = bib_pkg::CFG_GRAVITY_X; cfg_data = '0;
        arena_w = 800; arena_h = 600;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed balls under the reset settings.
        send_ball(32'd400 << 16, 32'd300 << 16, 32'd0, 32'd0, 11'd10, 17'd65536);
        send_ball(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 11'd2047, 17'h1ffff);
        send_ball(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 11'd0, 17'd0);
        send_ball(32'd0, 32'd300 << 16, 32'h80000000, 32'd0, 11'd5, 17'd40000);
        send_ball(32'd799 << 16, 32'd300 << 16, 32'd3 << 16, 32'hffff0000, 11'd5, 17'd65537);
        send_ball(32'd400 << 16, 32'd599 << 16, 32'd1 << 16, 32'd5 << 16, 11'd3, 17'd30000);
        send_ball(32'd400 << 16, 32'd0, 32'd7 << 16, 32'hfff00000, 11'd3, 17'd1);
        send_ball(32'd1 << 16, 32'd1 << 16, 32'hfffe0000, 32'hfffc0000, 11'd8, 17'd50000);
        send_ball(32'd400 << 16, 32'd300 << 16, 32'd0, 32'd0, 11'd2047, 17'd65535);
        send_ball(32'd2, 32'd300 << 16, 32'd0, 32'hffff0000, 11'd1, 17'd20000);
        send_ball(32'd790 << 16, 32'd590 << 16, 32'd20 << 16, 32'd20 << 16, 11'd0, 17'd9);
        send_ball(32'd0, 32'd300 << 16, 32'hffffffff, 32'h7fffffff, 11'd4, 17'd65536);
        pause(3);

        // Zero gravity, extreme gravity and degenerate arenas, then ordinary and random settings.
        setup_arena(32'd0, 32'd0, 32'd0, 32'd16383);
        send_ball(32'd0, 32'd100 << 16, 32'd0, 32'd0, 11'd0, 17'd65536);
        send_ball(32'd5 << 16, 32'd100 << 16, 32'd1, 32'd0, 11'd0, 17'd12345);
        send_ball(32'd5 << 16, 32'd1, 32'd0, 32'hffffffff, 11'd0, 17'd12345);
        random_balls(150);
        setup_arena(32'h80000000, 32'h7fffffff, 32'd1, 32'd1);
        random_balls(150);
        setup_arena(32'h7fffffff, 32'h80000000, 32'd8192, 32'd8192);
        random_balls(150);
        setup_arena(32'hffff8000, 32'd65536, 32'd640, 32'd480);
        random_balls(500);
        setup_arena($urandom_range(0, 65535) - 32768, $urandom_range(0, 131071),
                    $urandom_range(1, 8192), $urandom_range(1, 8192));
        random_balls(300);
        // Hold off until every frame is back, then carry on with the same settings.
        while (pending != 0) @(negedge i_clk);
        random_balls(430);

        while (pending != 0) @(negedge i_clk);
        repeat (bib_pkg::LATENCY + 10) @(negedge i_clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

// ----- filelist.f -----
design/bib_pkg.sv
design/bib_sqrt.sv
design/bib_div.sv
design/bib_damp.sv
design/ball_integrate_and_wall_bounce.sv
design/bib_checker.sv
verif/ball_bounce_checker.sv
verif/tb_ball_integrate_and_wall_bounce.sv
